// ===== hdl/mandelbrot_escape_time_pixel_core_macros.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define METP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define METP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define METP_ASSERT_IMP(name, clk, rst, ante, cons, msg)

`define METP_ASSERT_NXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/metp_pkg.sv =====
// ----------------------------------------------------------------------------
// metp_pkg
// Widths, reset values and register indices of the escape-time core.
// ----------------------------------------------------------------------------
package metp_pkg;

  // payload and register widths
  localparam int PixelW  = 12;
  localparam int WidthW  = 13;
  localparam int HeightW = 13;
  localparam int LimitW  = 16;
  localparam int CountW  = 16;

  // configuration port
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] RegImageWidth     = 2'd0;
  localparam logic [CfgAddrW-1:0] RegImageHeight    = 2'd1;
  localparam logic [CfgAddrW-1:0] RegIterationLimit = 2'd2;

  localparam logic [WidthW-1:0]  ResetImageWidth     = 13'd1200;
  localparam logic [HeightW-1:0] ResetImageHeight    = 13'd800;
  localparam logic [LimitW-1:0]  ResetIterationLimit = 16'd30;

  // parameter defaults
  localparam int CoordBitsDefault = 12;
  localparam int FracBitsDefault  = 28;

  // coordinate mapping: numerators, denominator 10*h and division remainder
  localparam int NumW = 20;
  localparam int DenW = 17;
  localparam int RemW = 18;

  // multiplier digit width, second operand is consumed this many bits a cycle
  localparam int MulDigitW = 16;

endpackage

// ===== hdl/mandelbrot_escape_time_pixel_core.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core
// Steps: S_MAP maps the coordinate, S_PREP the integer part, S_DIV the fraction
// bits, then S_CHECK, S_MUL and S_UPDATE for each iteration. A pixel stops on
// the limit or the range check, or when |z|^2 > 4 ends it; a point off the
// plane or a zero limit goes from S_PREP to S_FINISH. One pixel at a time, the
// next once the result is registered; three shared products per iteration.
// Synchronous reset restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_core_macros.svh"

module mandelbrot_escape_time_pixel_core #(
  parameter int COORD_BITS = metp_pkg::CoordBitsDefault,
  parameter int FRAC_BITS  = metp_pkg::FracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [metp_pkg::CfgAddrW-1:0] cfg_index,
  input  logic [metp_pkg::CfgDataW-1:0] cfg_data,
  // pixel in
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [metp_pkg::PixelW-1:0]   pixel_x,
  input  logic [metp_pkg::PixelW-1:0]   pixel_y,
  // result out
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [metp_pkg::CountW-1:0]   iteration_count,
  output logic                          escaped
);

  import metp_pkg::*;

  localparam int ZW      = FRAC_BITS + 5;   // z, signed, up to +-16
  localparam int CW      = FRAC_BITS + 3;   // c signed, square magnitudes
  localparam int MW      = FRAC_BITS + 2;   // operand magnitude, up to 2.0
  localparam int NDig    = (MW + MulDigitW - 1) / MulDigitW;
  localparam int BPadW   = NDig * MulDigitW;
  localparam int AccW    = MW + BPadW;
  localparam int PW      = MW + MulDigitW;
  localparam int StepW   = $clog2(FRAC_BITS);
  localparam int DigIdxW = (NDig > 1) ? $clog2(NDig) : 1;

  localparam logic [PixelW-1:0] CoordMask =
    (COORD_BITS >= PixelW) ? {PixelW{1'b1}} : PixelW'((1 << COORD_BITS) - 1);

  localparam logic signed [ZW-1:0] FxTwo    = {3'b000, 1'b1, {(FRAC_BITS+1){1'b0}}};
  localparam logic signed [ZW-1:0] FxTwoNeg = -FxTwo;
  localparam logic [CW:0]          FxFour   = {2'b01, {(FRAC_BITS+2){1'b0}}};
  localparam logic [CW-1:0]        FxFourSq = {1'b1, {(FRAC_BITS+2){1'b0}}};
  localparam logic [MW-1:0]        MaxMag   = {1'b1, {(FRAC_BITS+1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_PREP, S_DIV, S_CHECK, S_MUL, S_UPDATE, S_FINISH
  } state_t;

  typedef enum logic [1:0] {OP_RR, OP_II, OP_RI} mul_op_t;

  typedef struct packed {
    logic [1:0]      q;
    logic [RemW-1:0] r;
  } int_div_t;

  typedef struct packed {
    logic            b;
    logic [RemW-1:0] r;
  } div_bit_t;

  // integer part of |n|/d, valid for |n| <= 2d
  function automatic int_div_t int_step(input logic [NumW-1:0] n,
                                        input logic [DenW-1:0] d);
    int_div_t res;
    if (n == NumW'({d, 1'b0})) begin
      res.q = 2'd2;
      res.r = '0;
    end else if (n >= NumW'(d)) begin
      res.q = 2'd1;
      res.r = RemW'(n - NumW'(d));
    end else begin
      res.q = 2'd0;
      res.r = n[RemW-1:0];
    end
    return res;
  endfunction

  // one restoring division step
  function automatic div_bit_t div_step(input logic [RemW-1:0] r,
                                        input logic [DenW-1:0] d);
    div_bit_t        res;
    logic [RemW:0]   r2;
    r2 = {r, 1'b0};
    if (r2 >= (RemW+1)'(d)) begin
      res.b = 1'b1;
      res.r = RemW'(r2 - (RemW+1)'(d));
    end else begin
      res.b = 1'b0;
      res.r = r2[RemW-1:0];
    end
    return res;
  endfunction

  state_t  state;
  mul_op_t op;

  logic [WidthW-1:0]  image_width;
  logic [HeightW-1:0] image_height;
  logic [LimitW-1:0]  iteration_limit;

  logic [PixelW-1:0]      px, py;
  logic signed [NumW-1:0] n_re, n_im;
  logic [DenW-1:0]        den;
  logic                   neg_re, neg_im;
  logic [RemW-1:0]        rem_re, rem_im;
  logic [MW-1:0]          q_re, q_im;
  logic signed [CW-1:0]   c_re, c_im;
  logic signed [ZW-1:0]   z_re, z_im;
  logic [MW-1:0]          zr_mag, zi_mag;
  logic                   ri_neg;
  logic [CW-1:0]          sq_re, sq_im, prod_ri;
  logic [AccW-1:0]        acc;
  logic [StepW-1:0]       step;
  logic [CountW-1:0]      count;
  logic                   esc;

  // coordinate mapping
  logic [HeightW-1:0]     h_eff;
  logic signed [NumW-1:0] n_re_calc, n_im_calc;
  logic [DenW-1:0]        den_calc;
  logic [NumW-1:0]        abs_re, abs_im;
  logic                   in_plane;
  int_div_t               int_re, int_im;
  div_bit_t               bit_re, bit_im;
  logic [MW-1:0]          q_re_next, q_im_next;

  // shared multiplier
  logic [MW-1:0]          mul_a, mul_b;
  logic [BPadW-1:0]       mul_b_pad;
  logic [DigIdxW-1:0]     dig_idx;
  logic [MulDigitW-1:0]   mul_digit;
  logic [PW-1:0]          mul_prod;
  logic [AccW-1:0]        acc_next;
  logic [CW-1:0]          mul_res;

  // iteration
  logic                   outside;
  logic [CW:0]            mag_sq;
  logic signed [ZW-1:0]   ri2, z_re_next, z_im_next;

  assign in_ready = (state == S_IDLE);

  assign h_eff     = (image_height == '0) ? HeightW'(1) : image_height;
  assign n_re_calc = $signed(NumW'(px) * NumW'(24) - NumW'(image_width) * NumW'(12)
                             - NumW'(h_eff) * NumW'(5));
  assign n_im_calc = $signed(NumW'(py) * NumW'(24) - NumW'(h_eff) * NumW'(12));
  assign den_calc  = DenW'(h_eff) * DenW'(10);

  assign abs_re   = n_re[NumW-1] ? NumW'(-n_re) : NumW'(n_re);
  assign abs_im   = n_im[NumW-1] ? NumW'(-n_im) : NumW'(n_im);
  assign in_plane = (abs_re <= NumW'({den, 1'b0})) && (abs_im <= NumW'({den, 1'b0}));
  assign int_re   = int_step(abs_re, den);
  assign int_im   = int_step(abs_im, den);

  assign bit_re    = div_step(rem_re, den);
  assign bit_im    = div_step(rem_im, den);
  assign q_re_next = {q_re[MW-2:0], bit_re.b};
  assign q_im_next = {q_im[MW-2:0], bit_im.b};

  always_comb begin
    case (op)
      OP_RR:   begin mul_a = zr_mag; mul_b = zr_mag; end
      OP_II:   begin mul_a = zi_mag; mul_b = zi_mag; end
      OP_RI:   begin mul_a = zr_mag; mul_b = zi_mag; end
      default: begin mul_a = zr_mag; mul_b = zi_mag; end
    endcase
  end

  // most significant digit first
  assign mul_b_pad = BPadW'(mul_b);
  assign dig_idx   = DigIdxW'(NDig - 1) - step[DigIdxW-1:0];
  assign mul_digit = mul_b_pad[dig_idx*MulDigitW +: MulDigitW];
  assign mul_prod  = PW'(mul_a) * PW'(mul_digit);
  assign acc_next  = (step == '0) ? AccW'(mul_prod)
                                  : (acc << MulDigitW) + AccW'(mul_prod);
  assign mul_res   = acc_next[FRAC_BITS +: CW];

  assign outside = (z_re > FxTwo) || (z_re < FxTwoNeg) ||
                   (z_im > FxTwo) || (z_im < FxTwoNeg);
  assign mag_sq  = (CW+1)'(sq_re) + (CW+1)'(sq_im);

  assign ri2       = $signed({1'b0, prod_ri, 1'b0});
  assign z_re_next = $signed({2'b00, sq_re}) - $signed({2'b00, sq_im}) + ZW'(c_re);
  assign z_im_next = (ri_neg ? -ri2 : ri2) + ZW'(c_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      op              <= OP_RR;
      step            <= '0;
      out_valid       <= 1'b0;
      image_width     <= ResetImageWidth;
      image_height    <= ResetImageHeight;
      iteration_limit <= ResetIterationLimit;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegImageWidth:     image_width     <= cfg_data[WidthW-1:0];
          RegImageHeight:    image_height    <= cfg_data[HeightW-1:0];
          RegIterationLimit: iteration_limit <= cfg_data[LimitW-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            px    <= pixel_x & CoordMask;
            py    <= pixel_y & CoordMask;
            count <= '0;
            state <= S_MAP;
          end
        end

        S_MAP: begin
          n_re  <= n_re_calc;
          n_im  <= n_im_calc;
          den   <= den_calc;
          state <= S_PREP;
        end

        S_PREP: begin
          neg_re <= n_re[NumW-1];
          neg_im <= n_im[NumW-1];
          rem_re <= int_re.r;
          rem_im <= int_im.r;
          q_re   <= MW'(int_re.q);
          q_im   <= MW'(int_im.q);
          step   <= '0;
          if (iteration_limit == '0 || !in_plane) begin
            esc   <= (iteration_limit != '0);
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          rem_re <= bit_re.r;
          rem_im <= bit_im.r;
          q_re   <= q_re_next;
          q_im   <= q_im_next;
          if (step == StepW'(FRAC_BITS - 1)) begin
            c_re  <= neg_re ? -$signed({1'b0, q_re_next}) : $signed({1'b0, q_re_next});
            c_im  <= neg_im ? -$signed({1'b0, q_im_next}) : $signed({1'b0, q_im_next});
            z_re  <= ZW'(neg_re ? -$signed({1'b0, q_re_next}) : $signed({1'b0, q_re_next}));
            z_im  <= ZW'(neg_im ? -$signed({1'b0, q_im_next}) : $signed({1'b0, q_im_next}));
            step  <= '0;
            state <= S_CHECK;
          end else begin
            step <= step + StepW'(1);
          end
        end

        S_CHECK: begin
          zr_mag <= MW'(z_re[ZW-1] ? -z_re : z_re);
          zi_mag <= MW'(z_im[ZW-1] ? -z_im : z_im);
          ri_neg <= z_re[ZW-1] ^ z_im[ZW-1];
          op     <= OP_RR;
          step   <= '0;
          if (count >= iteration_limit) begin
            esc   <= 1'b0;
            state <= S_FINISH;
          end else if (outside) begin
            esc   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_MUL;
          end
        end

        S_MUL: begin
          acc <= acc_next;
          if (step == StepW'(NDig - 1)) begin
            step <= '0;
            case (op)
              OP_RR: begin
                sq_re <= mul_res;
                op    <= OP_II;
              end
              OP_II: begin
                sq_im <= mul_res;
                op    <= OP_RI;
              end
              default: begin
                prod_ri <= mul_res;
                state   <= S_UPDATE;
              end
            endcase
          end else begin
            step <= step + StepW'(1);
          end
        end

        S_UPDATE: begin
          if (mag_sq > FxFour) begin
            esc   <= 1'b1;
            state <= S_FINISH;
          end else begin
            z_re  <= z_re_next;
            z_im  <= z_im_next;
            count <= count + CountW'(1);
            state <= S_CHECK;
          end
        end

        S_FINISH: begin
          // result register frees up on the same edge it is taken
          if (!out_valid || out_ready) begin
            iteration_count <= count;
            escaped         <= esc;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `METP_ASSERT_IMP(a_mag_bound, clk, rst, state == S_MUL, zr_mag <= MaxMag && zi_mag <= MaxMag, "operand above 2.0 in multiplier")
  `METP_ASSERT_IMP(a_sq_bound, clk, rst, state == S_UPDATE, sq_re <= FxFourSq && sq_im <= FxFourSq, "square above 4.0")
  `METP_ASSERT_IMP(a_out_src, clk, rst, $rose(out_valid), $past(state == S_FINISH), "result word without finish")
  `METP_ASSERT_NXT(a_mul_flow, clk, rst, state == S_MUL, state == S_MUL || state == S_UPDATE, "multiply sequence broken")

endmodule
